// ===== sv/hashed_word_tokenizer_defines.svh =====
// Assertion macros shared by the tokenizer RTL
`ifndef HASHED_WORD_TOKENIZER_DEFINES_SVH
`define HASHED_WORD_TOKENIZER_DEFINES_SVH

// Check a property at every rising edge of clk_i outside reset
`define HWT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds at a rising edge of clk_i outside reset
`define HWT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== sv/hwt_pkg.sv =====
// Types, constants and codes shared by the tokenizer modules
`default_nettype none

package hwt_pkg;

  // Limits of the design
  localparam int unsigned MaxImages = 8;
  localparam int unsigned MaxTokens = 4096;

  // Field widths
  localparam int unsigned FuncW  = 2;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned TokW   = 31;
  localparam int unsigned CntW   = 13;
  localparam int unsigned ImgW   = 4;
  localparam int unsigned CfgDW  = 13;
  localparam int unsigned CfgIW  = 2;
  localparam int unsigned HashW  = 32;
  localparam int unsigned ResW   = 15;
  localparam int unsigned NumW   = 4;   // up to one word token plus MaxImages results
  localparam int unsigned DelimW = 4;

  // Token values
  localparam logic [TokW-1:0]   ImgBase    = 31'h7FFF_FFF0;
  localparam logic [DelimW-1:0] TokSpace   = 4'd0;
  localparam logic [DelimW-1:0] TokNewline = 4'd13;

  // Word hash constants
  localparam logic [HashW-1:0] HashInit = 32'd5381;
  localparam logic [ResW-1:0]  HashMod  = 15'd31999;
  localparam int unsigned      AddW     = 17;
  localparam int unsigned      RedW     = 21;
  localparam int unsigned      CarryW   = 6;
  // Adding this per unit of carry out of bit 31 stands for subtracting 2^32 mod HashMod
  localparam logic [AddW-1:0]  HashWrapAdj =
    AddW'(HashMod) - AddW'(33'h1_0000_0000 % 33'(HashMod));

  // Characters
  localparam logic [ByteW-1:0] ChSpace   = 8'h20;
  localparam logic [ByteW-1:0] ChTab     = 8'h09;
  localparam logic [ByteW-1:0] ChNewline = 8'h0A;

  typedef enum logic [FuncW-1:0] {
    FuncStart = 2'd0,
    FuncByte  = 2'd1,
    FuncEnd   = 2'd2
  } func_e;

  typedef enum logic [CfgIW-1:0] {
    CfgLayout = 2'd0,
    CfgImages = 2'd1,
    CfgLimit  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    LayoutSingle    = 2'd0,
    LayoutNumbered  = 2'd1,
    LayoutSingleAlt = 2'd2,
    LayoutAfter     = 2'd3
  } layout_e;

  // Configuration as the datapath sees it
  typedef struct packed {
    layout_e         layout;
    logic [ImgW-1:0] n_img;   // saturated at MaxImages
    logic [CntW-1:0] limit;   // min(token_limit, MaxTokens)
  } cfg_t;

  // Word hash commands, one transaction at most per cycle
  typedef struct packed {
    logic             extend;
    logic             clear;
    logic [ByteW-1:0] ch;
  } hash_ctl_t;

  // All results of one input item
  typedef struct packed {
    logic              word_vld;
    logic [ResW-1:0]   word_res;
    logic              tail_img;
    logic              tail_num;
    logic [DelimW-1:0] tail_tok;
    logic [NumW-1:0]   num;
    logic [CntW-1:0]   cnt_base;
  } batch_t;

endpackage

`default_nettype wire

// ===== sv/hwt_cfg_regs.sv =====
// Configuration registers of the tokenizer
`default_nettype none

module hwt_cfg_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [hwt_pkg::CfgIW-1:0]  cfg_index_i,
  input  wire logic [hwt_pkg::CfgDW-1:0]  cfg_data_i,
  output hwt_pkg::cfg_t                   cfg_o
);

  hwt_pkg::layout_e              layout_q;
  logic [hwt_pkg::ImgW-1:0]      img_q;
  logic [hwt_pkg::CntW-1:0]      limit_q;

  assign cfg_ready_o = 1'b1;

  // Write one register per transaction, ignore unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layout_q <= hwt_pkg::LayoutSingle;
      img_q    <= '0;
      limit_q  <= hwt_pkg::CntW'(hwt_pkg::MaxTokens);
    end else if (cfg_valid_i) begin
      unique case (hwt_pkg::cfg_idx_e'(cfg_index_i))
        hwt_pkg::CfgLayout: layout_q <= hwt_pkg::layout_e'(cfg_data_i[1:0]);
        hwt_pkg::CfgImages: img_q    <= cfg_data_i[hwt_pkg::ImgW-1:0];
        hwt_pkg::CfgLimit:  limit_q  <= cfg_data_i[hwt_pkg::CntW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Saturate image count and clamp the limit
  always_comb begin
    cfg_o.layout = layout_q;
    cfg_o.n_img  = (img_q > hwt_pkg::ImgW'(hwt_pkg::MaxImages)) ?
                   hwt_pkg::ImgW'(hwt_pkg::MaxImages) : img_q;
    cfg_o.limit  = (limit_q > hwt_pkg::CntW'(hwt_pkg::MaxTokens)) ?
                   hwt_pkg::CntW'(hwt_pkg::MaxTokens) : limit_q;
  end

endmodule

`default_nettype wire

// ===== sv/hwt_word_hash.sv =====
// djb2 word hash with a running residue modulo the token range
`default_nettype none
`include "hashed_word_tokenizer_defines.svh"

module hwt_word_hash (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire hwt_pkg::hash_ctl_t        ctl_i,
  output logic                           in_word_o,
  output logic [hwt_pkg::ResW-1:0]       word_res_o
);

  logic [hwt_pkg::HashW-1:0]          hash_q;
  logic                               in_word_q;
  logic [hwt_pkg::ResW-1:0]           res_q;       // residue before the pending byte
  logic                               pend_vld_q;
  logic [hwt_pkg::AddW-1:0]           pend_add_q;  // byte plus wrap correction

  logic [hwt_pkg::HashW+hwt_pkg::CarryW-1:0] wide;
  logic [hwt_pkg::CarryW-1:0]         carry;
  logic [hwt_pkg::AddW-1:0]           add_next;
  logic [hwt_pkg::RedW-1:0]           red_x;
  logic [hwt_pkg::CarryW-1:0]         red_hi;
  logic [hwt_pkg::RedW-1:0]           red_y;
  logic [hwt_pkg::ResW-1:0]           red_r;
  logic [hwt_pkg::ResW-1:0]           cur_res;

  // Full hash step h*33 + c, keep the carry out of bit 31
  always_comb begin
    wide = ({hwt_pkg::CarryW'(0), hash_q} << 5) + {hwt_pkg::CarryW'(0), hash_q}
           + (hwt_pkg::HashW+hwt_pkg::CarryW)'(ctl_i.ch);
    carry = wide[hwt_pkg::HashW +: hwt_pkg::CarryW];
    add_next = hwt_pkg::AddW'(ctl_i.ch)
             + hwt_pkg::AddW'(carry) * hwt_pkg::HashWrapAdj;
  end

  // Apply the pending byte to the residue: x stays below 36 moduli,
  // its top bits give a quotient at most one too small
  always_comb begin
    red_x  = (hwt_pkg::RedW'(res_q) << 5) + hwt_pkg::RedW'(res_q)
           + hwt_pkg::RedW'(pend_add_q);
    red_hi = red_x[hwt_pkg::RedW-1 -: hwt_pkg::CarryW];
    red_y  = red_x - hwt_pkg::RedW'(red_hi) * hwt_pkg::RedW'(hwt_pkg::HashMod);
    red_r  = (red_y >= hwt_pkg::RedW'(hwt_pkg::HashMod)) ?
             hwt_pkg::ResW'(red_y - hwt_pkg::RedW'(hwt_pkg::HashMod)) :
             hwt_pkg::ResW'(red_y);
    cur_res = pend_vld_q ? red_r : res_q;
  end

  assign in_word_o  = in_word_q;
  assign word_res_o = cur_res;

  // Restart or extend the word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q     <= hwt_pkg::HashInit;
      in_word_q  <= 1'b0;
      res_q      <= hwt_pkg::ResW'(hwt_pkg::HashInit);
      pend_vld_q <= 1'b0;
      pend_add_q <= '0;
    end else if (ctl_i.clear) begin
      hash_q     <= hwt_pkg::HashInit;
      in_word_q  <= 1'b0;
      res_q      <= hwt_pkg::ResW'(hwt_pkg::HashInit);
      pend_vld_q <= 1'b0;
    end else if (ctl_i.extend) begin
      hash_q     <= wide[hwt_pkg::HashW-1:0];
      in_word_q  <= 1'b1;
      res_q      <= cur_res;
      pend_vld_q <= 1'b1;
      pend_add_q <= add_next;
    end
  end

  `HWT_ASSERT(a_res_range, res_q < hwt_pkg::HashMod && cur_res < hwt_pkg::HashMod, "hash residue out of range")
  `HWT_NEVER(a_ctl_excl, ctl_i.clear && ctl_i.extend, "hash clear and extend together")

endmodule

`default_nettype wire

// ===== sv/hwt_planner.sv =====
// Input register, token count and result planning for one item
`default_nettype none
`include "hashed_word_tokenizer_defines.svh"

module hwt_planner (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [hwt_pkg::FuncW-1:0]  func_i,
  input  wire logic [hwt_pkg::ByteW-1:0]  text_byte_i,
  input  wire hwt_pkg::cfg_t              cfg_i,
  input  wire logic                       in_word_i,
  input  wire logic [hwt_pkg::ResW-1:0]   word_res_i,
  output hwt_pkg::hash_ctl_t              hash_ctl_o,
  input  wire logic                       batch_free_i,
  output logic                            load_o,
  output hwt_pkg::batch_t                 batch_o
);

  logic                            in_vld_q;
  logic [hwt_pkg::FuncW-1:0]       func_q;
  logic [hwt_pkg::ByteW-1:0]       byte_q;
  logic [hwt_pkg::CntW-1:0]        cnt_q;

  hwt_pkg::hash_ctl_t              hctl;
  logic                            restart;
  logic                            word_vld;
  logic [hwt_pkg::NumW-1:0]        tail_cnt;
  logic                            tail_img;
  logic                            tail_num;
  logic [hwt_pkg::DelimW-1:0]      tail_tok;
  logic [hwt_pkg::CntW-1:0]        base;
  logic [hwt_pkg::CntW-1:0]        avail;
  logic [hwt_pkg::NumW-1:0]        total;
  logic [hwt_pkg::NumW-1:0]        nres;
  logic                            move;

  // Decode the item into a word flush and a run of tail tokens
  always_comb begin
    hctl     = '0;
    hctl.ch  = byte_q;
    restart  = 1'b0;
    word_vld = 1'b0;
    tail_cnt = '0;
    tail_img = 1'b0;
    tail_num = 1'b0;
    tail_tok = hwt_pkg::TokSpace;
    unique case (hwt_pkg::func_e'(func_q))
      hwt_pkg::FuncStart: begin
        restart    = 1'b1;
        hctl.clear = 1'b1;
        tail_img   = 1'b1;
        unique case (cfg_i.layout)
          hwt_pkg::LayoutSingle, hwt_pkg::LayoutSingleAlt: begin
            tail_cnt = (cfg_i.n_img != '0) ? hwt_pkg::NumW'(1) : '0;
          end
          hwt_pkg::LayoutNumbered: begin
            tail_cnt = hwt_pkg::NumW'(cfg_i.n_img);
            tail_num = 1'b1;
          end
          hwt_pkg::LayoutAfter: begin
            tail_cnt = '0;
          end
          default: begin
          end
        endcase
      end
      hwt_pkg::FuncByte: begin
        priority if (byte_q == hwt_pkg::ChSpace || byte_q == hwt_pkg::ChTab ||
                     byte_q == hwt_pkg::ChNewline) begin
          hctl.clear = 1'b1;
          word_vld   = in_word_i;
          tail_cnt   = hwt_pkg::NumW'(1);
          tail_tok   = (byte_q == hwt_pkg::ChNewline) ? hwt_pkg::TokNewline
                                                     : hwt_pkg::TokSpace;
        end else if (byte_q != '0) begin
          hctl.extend = 1'b1;
        end else begin
          // drop a zero byte
        end
      end
      hwt_pkg::FuncEnd: begin
        hctl.clear = 1'b1;
        word_vld   = in_word_i;
        if (cfg_i.layout == hwt_pkg::LayoutAfter) begin
          tail_cnt = hwt_pkg::NumW'(cfg_i.n_img);
          tail_img = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Clip the results at the token limit
  always_comb begin
    base  = restart ? '0 : cnt_q;
    avail = (base >= cfg_i.limit) ? '0 : cfg_i.limit - base;
    total = hwt_pkg::NumW'(word_vld) + tail_cnt;
    nres  = (avail < hwt_pkg::CntW'(total)) ? avail[hwt_pkg::NumW-1:0] : total;
  end

  // Items without results pass even while the emitter is busy
  assign move       = in_vld_q && (nres == '0 || batch_free_i);
  assign in_ready_o = !in_vld_q || move;
  assign load_o     = move && (nres != '0);
  assign hash_ctl_o = move ? hctl
                           : hwt_pkg::hash_ctl_t'{extend: 1'b0, clear: 1'b0, ch: byte_q};

  always_comb begin
    batch_o.word_vld = word_vld;
    batch_o.word_res = word_res_i;
    batch_o.tail_img = tail_img;
    batch_o.tail_num = tail_num;
    batch_o.tail_tok = tail_tok;
    batch_o.num      = nres;
    batch_o.cnt_base = base;
  end

  // Hold the input transaction and the prompt token count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (move) begin
        cnt_q <= base + hwt_pkg::CntW'(nres);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      func_q <= func_i;
      byte_q <= text_byte_i;
    end
  end

  `HWT_ASSERT(a_cnt_max, cnt_q <= hwt_pkg::CntW'(hwt_pkg::MaxTokens), "token count above maximum")

endmodule

`default_nettype wire

// ===== sv/hwt_emitter.sv =====
// Result register: steps through the tokens of one planned item
`default_nettype none
`include "hashed_word_tokenizer_defines.svh"

module hwt_emitter (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       load_i,
  input  wire hwt_pkg::batch_t            batch_i,
  output logic                            batch_free_o,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [hwt_pkg::TokW-1:0]        token_o,
  output logic [hwt_pkg::CntW-1:0]        tokens_so_far_o,
  output logic                            last_o
);

  logic                         vld_q;
  logic [hwt_pkg::NumW-1:0]     idx_q;
  hwt_pkg::batch_t              b_q;
  logic [hwt_pkg::NumW-1:0]     tail_idx;
  logic                         is_last;

  assign is_last      = (idx_q == b_q.num - hwt_pkg::NumW'(1));
  assign batch_free_o = !vld_q || (out_ready_i && is_last);
  assign tail_idx     = idx_q - hwt_pkg::NumW'(b_q.word_vld);

  // Select the token at the current position
  always_comb begin
    if (b_q.word_vld && idx_q == '0) begin
      token_o = hwt_pkg::TokW'(b_q.word_res) + hwt_pkg::TokW'(1);
    end else if (b_q.tail_img) begin
      token_o = hwt_pkg::ImgBase + (b_q.tail_num ? hwt_pkg::TokW'(tail_idx) : '0);
    end else begin
      token_o = hwt_pkg::TokW'(b_q.tail_tok);
    end
  end

  assign out_valid_o     = vld_q;
  assign tokens_so_far_o = b_q.cnt_base + hwt_pkg::CntW'(idx_q) + hwt_pkg::CntW'(1);
  assign last_o          = is_last;

  // Load a new item or advance to the next token
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else if (load_i) begin
      vld_q <= 1'b1;
      idx_q <= '0;
    end else if (vld_q && out_ready_i) begin
      if (is_last) begin
        vld_q <= 1'b0;
      end else begin
        idx_q <= idx_q + hwt_pkg::NumW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      b_q <= batch_i;
    end
  end

  `HWT_ASSERT(a_idx_range, vld_q |-> (idx_q < b_q.num), "result index past item end")
  `HWT_ASSERT(a_run_on, (vld_q && out_ready_i && !is_last) |=> vld_q, "item dropped before last token")

endmodule

`default_nettype wire

// ===== sv/hashed_word_tokenizer.sv =====
// Top level of the hashed word tokenizer
//
//   channel  direction  handshake             payload
//   in       sink       in_valid_i/in_ready_o  func_i, text_byte_i
//   out      source     out_valid_o/out_ready_i token_o, tokens_so_far_o, last_o
//   cfg      sink       cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// An item is planned while it sits in the input register and loads the result register
// once that register is free. Items without results never wait for the output.
// Results leave at one per cycle from the result register while out_ready_i is high;
// an item holds the result register until its last result is taken, so the input
// takes one item per cycle while each gives at most one token and the output is ready.
// The word residue is updated incrementally, one byte per cycle while input flows.
// Reset is asynchronous, active low, and clears configuration and prompt state.
`default_nettype none

module hashed_word_tokenizer (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [hwt_pkg::FuncW-1:0]  func_i,
  input  wire logic [hwt_pkg::ByteW-1:0]  text_byte_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [hwt_pkg::TokW-1:0]        token_o,
  output logic [hwt_pkg::CntW-1:0]        tokens_so_far_o,
  output logic                            last_o,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [hwt_pkg::CfgIW-1:0]  cfg_index_i,
  input  wire logic [hwt_pkg::CfgDW-1:0]  cfg_data_i
);

  hwt_pkg::cfg_t                 cfg;
  hwt_pkg::hash_ctl_t            hash_ctl;
  hwt_pkg::batch_t               batch;
  logic                          in_word;
  logic [hwt_pkg::ResW-1:0]      word_res;
  logic                          batch_free;
  logic                          load;

  hwt_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  hwt_word_hash u_hash (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (hash_ctl),
    .in_word_o  (in_word),
    .word_res_o (word_res)
  );

  hwt_planner u_plan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .text_byte_i  (text_byte_i),
    .cfg_i        (cfg),
    .in_word_i    (in_word),
    .word_res_i   (word_res),
    .hash_ctl_o   (hash_ctl),
    .batch_free_i (batch_free),
    .load_o       (load),
    .batch_o      (batch)
  );

  hwt_emitter u_emit (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (load),
    .batch_i         (batch),
    .batch_free_o    (batch_free),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .token_o         (token_o),
    .tokens_so_far_o (tokens_so_far_o),
    .last_o          (last_o)
  );

endmodule

`default_nettype wire

// ===== tb/sv/hashed_word_tokenizer_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the hashed word tokenizer: predicts tokens and checks the output channel
module hashed_word_tokenizer_checker
  import hwt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [FuncW-1:0]     func_i,
  input  logic [ByteW-1:0]     text_byte_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [TokW-1:0]      token_i,
  input  logic [CntW-1:0]      tokens_so_far_i,
  input  logic                 last_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CfgIW-1:0]     cfg_index_i,
  input  logic [CfgDW-1:0]     cfg_data_i,
  output int unsigned          fail_cnt_o,
  output int unsigned          checked_cnt_o,
  output int unsigned          pending_cnt_o
);

  typedef struct packed {
    logic [TokW-1:0] token;
    logic [CntW-1:0] count;
    logic            last;
  } token_rec_t;

  // Register copies
  layout_e         layout_q;
  logic [ImgW-1:0] images_q;
  logic [CntW-1:0] limit_q;

  // Prompt state
  logic [HashW-1:0] hash_q;
  logic             in_word_q;
  logic [CntW-1:0]  count_q;

  token_rec_t tokens_due[$];
  token_rec_t item_toks[$];
  token_rec_t got_tok;
  token_rec_t due_tok;

  int unsigned fail_cnt    = 0;
  int unsigned checked_cnt = 0;
  int unsigned pending_cnt = 0;

  assign fail_cnt_o    = fail_cnt;
  assign checked_cnt_o = checked_cnt;
  assign pending_cnt_o = pending_cnt;

  // Append one token for the current item unless the prompt limit is reached
  task automatic emit_token(input logic [TokW-1:0] tok);
    logic [CntW-1:0] cap;
    cap = (limit_q > CntW'(MaxTokens)) ? CntW'(MaxTokens) : limit_q;
    if (count_q >= cap) return;
    count_q = count_q + 1'b1;
    item_toks.push_back('{token: tok, count: count_q, last: 1'b0});
  endtask

  // Flush the open word and restart the hash
  task automatic close_word();
    if (in_word_q) begin
      emit_token(TokW'(hash_q % HashW'(HashMod)) + TokW'(1));
    end
    in_word_q = 1'b0;
    hash_q    = HashInit;
  endtask

  // Work out the tokens one accepted item causes and queue them
  task automatic tokenize_item(input logic [FuncW-1:0] f, input logic [ByteW-1:0] ch);
    logic [ImgW-1:0] n_img;
    token_rec_t      tail;
    n_img = (images_q > ImgW'(MaxImages)) ? ImgW'(MaxImages) : images_q;
    item_toks.delete();
    case (f)
      FuncStart: begin
        hash_q    = HashInit;
        in_word_q = 1'b0;
        count_q   = '0;
        if (layout_q == LayoutSingle || layout_q == LayoutSingleAlt) begin
          if (n_img != '0) emit_token(ImgBase);
        end else if (layout_q == LayoutNumbered) begin
          for (int i = 0; i < int'(n_img); i++) emit_token(ImgBase + TokW'(i));
        end
      end
      FuncByte: begin
        if (ch == ChSpace || ch == ChTab) begin
          close_word();
          emit_token(TokW'(TokSpace));
        end else if (ch == ChNewline) begin
          close_word();
          emit_token(TokW'(TokNewline));
        end else if (ch != '0) begin
          hash_q    = (hash_q << 5) + hash_q + HashW'(ch);
          in_word_q = 1'b1;
        end
      end
      FuncEnd: begin
        close_word();
        if (layout_q == LayoutAfter) begin
          for (int i = 0; i < int'(n_img); i++) emit_token(ImgBase);
        end
      end
      default: ;
    endcase
    // Mark the final token of this item
    if (item_toks.size() > 0) begin
      tail      = item_toks.pop_back();
      tail.last = 1'b1;
      item_toks.push_back(tail);
    end
    foreach (item_toks[k]) tokens_due.push_back(item_toks[k]);
  endtask

  // Track registers, predict on each input transaction, compare each output transaction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layout_q  = LayoutSingle;
      images_q  = '0;
      limit_q   = CntW'(MaxTokens);
      hash_q    = HashInit;
      in_word_q = 1'b0;
      count_q   = '0;
      tokens_due.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgLayout: layout_q = layout_e'(cfg_data_i[1:0]);
          CfgImages: images_q = cfg_data_i[ImgW-1:0];
          CfgLimit:  limit_q  = cfg_data_i[CntW-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        got_tok = '{token: token_i, count: tokens_so_far_i, last: last_i};
        if (tokens_due.size() == 0) begin
          $error("unexpected token: token %0h, tokens_so_far %0d, last %0b",
                 got_tok.token, got_tok.count, got_tok.last);
          fail_cnt++;
        end else begin
          due_tok = tokens_due.pop_front();
          checked_cnt++;
          if (got_tok.token !== due_tok.token) begin
            $error("token: expected %0h, actual %0h", due_tok.token, got_tok.token);
            fail_cnt++;
          end
          if (got_tok.count !== due_tok.count) begin
            $error("tokens_so_far: expected %0d, actual %0d", due_tok.count, got_tok.count);
            fail_cnt++;
          end
          if (got_tok.last !== due_tok.last) begin
            $error("last: expected %0b, actual %0b", due_tok.last, got_tok.last);
            fail_cnt++;
          end
        end
      end
      if (in_valid_i && in_ready_i) tokenize_item(func_i, text_byte_i);
    end
    pending_cnt = tokens_due.size();
  end

endmodule

// ===== tb/sv/hashed_word_tokenizer_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the hashed word tokenizer: stimulus, clock, reset and verdict
module hashed_word_tokenizer_tb;
  import hwt_pkg::*;

  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned RandomItems  = 150;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned LongDelims   = 50;
  localparam logic [FuncW-1:0] FuncUnused = 2'd3;
  localparam logic [CfgIW-1:0] CfgSpare   = 2'd3;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic [FuncW-1:0] func_i      = '0;
  logic [ByteW-1:0] text_byte_i = '0;
  logic             out_ready_i = 1'b0;
  logic             cfg_valid_i = 1'b0;
  logic [CfgIW-1:0] cfg_index_i = '0;
  logic [CfgDW-1:0] cfg_data_i  = '0;

  logic            in_ready_o;
  logic            out_valid_o;
  logic [TokW-1:0] token_o;
  logic [CntW-1:0] tokens_so_far_o;
  logic            last_o;
  logic            cfg_ready_o;

  int unsigned fail_cnt;
  int unsigned checked_cnt;
  int unsigned pending_cnt;

  bit          steady        = 1'b0;
  int unsigned cycle_cnt     = 0;
  int unsigned items_sent    = 0;
  int unsigned prompts_sent  = 0;
  int unsigned settings_used = 0;

  always #5 clk_i = ~clk_i;

  hashed_word_tokenizer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .func_i          (func_i),
    .text_byte_i     (text_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .token_o         (token_o),
    .tokens_so_far_o (tokens_so_far_o),
    .last_o          (last_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  hashed_word_tokenizer_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .func_i          (func_i),
    .text_byte_i     (text_byte_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .token_i         (token_o),
    .tokens_so_far_i (tokens_so_far_o),
    .last_i          (last_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .fail_cnt_o      (fail_cnt),
    .checked_cnt_o   (checked_cnt),
    .pending_cnt_o   (pending_cnt)
  );

  // Stall the output side now and then
  always @(negedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(0, 99) >= 7);
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Present one input transaction and hold it until accepted
  task automatic send_item(input logic [FuncW-1:0] f, input logic [ByteW-1:0] ch);
    @(negedge clk_i);
    if (!steady && $urandom_range(0, 99) < 7) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    func_i      <= f;
    text_byte_i <= ch;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    if (f == FuncStart) prompts_sent++;
  endtask

  // Drop valid and wait until every expected token has come out
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_cnt != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Write one register through the configuration channel
  task automatic write_reg(input logic [CfgIW-1:0] idx, input logic [CfgDW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Wait for idle, then load all three registers
  task automatic apply_setting(input logic [CfgDW-1:0] lay, input logic [CfgDW-1:0] img,
                               input logic [CfgDW-1:0] lim);
    drain();
    write_reg(CfgLayout, lay);
    write_reg(CfgImages, img);
    write_reg(CfgLimit, lim);
    settings_used++;
  endtask

  // Mostly letters, with delimiters and arbitrary nonzero bytes mixed in
  function automatic logic [ByteW-1:0] pick_text_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 8'h61 + ByteW'($urandom_range(0, 25));  // lowercase letter
    if (r < 60) return ChSpace;
    if (r < 65) return ChTab;
    if (r < 72) return ChNewline;
    return ByteW'($urandom_range(1, 255));
  endfunction

  // Send a prompt; start or end may be left off to break the sequence
  task automatic send_prompt(input int unsigned n_text, input bit with_start, input bit with_end);
    if (with_start) send_item(FuncStart, ByteW'($urandom_range(0, 255)));
    repeat (n_text) send_item(FuncByte, pick_text_byte());
    if (with_end) send_item(FuncEnd, ByteW'($urandom_range(0, 255)));
  endtask

  initial begin
    int unsigned base_items;
    int unsigned delims;
    int unsigned r;
    logic [CfgDW-1:0] lim;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Text before any start, zero byte, unused func, empty end, open word at end
    send_item(FuncByte, "h");
    send_item(FuncByte, "i");
    send_item(FuncByte, ChSpace);
    send_item(FuncByte, 8'h00);
    send_item(FuncUnused, 8'h5A);
    send_item(FuncByte, 8'hFF);
    send_item(FuncByte, 8'h01);
    send_item(FuncByte, ChTab);
    send_item(FuncByte, 8'h80);
    send_item(FuncByte, ChNewline);
    send_item(FuncEnd, 8'h00);
    send_item(FuncByte, "z");
    send_item(FuncEnd, 8'h00);
    send_item(FuncStart, 8'h00);

    // Numbered images, oversized count, limit cuts the run short
    apply_setting(CfgDW'(LayoutNumbered), 13'd15, 13'd5);
    write_reg(CfgSpare, 13'h1ABC);
    send_item(FuncStart, 8'h00);
    send_item(FuncByte, "a");
    send_item(FuncByte, ChSpace);
    send_item(FuncEnd, 8'h00);

    // Images after the text with a zero limit: nothing comes out
    apply_setting(CfgDW'(LayoutAfter), 13'd8, 13'd0);
    send_item(FuncStart, 8'h00);
    send_item(FuncByte, "q");
    send_item(FuncEnd, 8'h00);

    // Word plus all images on end: the largest burst
    drain();
    write_reg(CfgLimit, 13'd4096);
    send_item(FuncStart, 8'h00);
    send_item(FuncByte, "o");
    send_item(FuncByte, "k");
    send_item(FuncEnd, 8'h00);

    // Alternate single-image layout
    apply_setting(CfgDW'(LayoutSingleAlt), 13'd1, 13'd4096);
    send_item(FuncStart, 8'h00);
    send_item(FuncByte, "w");
    send_item(FuncByte, ChNewline);

    // Prompt with no idling, limit register set above the maximum
    apply_setting(CfgDW'(LayoutNumbered), 13'd8, 13'h1FFF);
    steady = 1'b1;
    send_item(FuncStart, 8'h00);
    delims = 0;
    while (delims < LongDelims) begin
      r = $urandom_range(0, 99);
      if (r < 90) begin
        delims++;
        send_item(FuncByte, (r < 60) ? ChSpace : ((r < 75) ? ChNewline : ChTab));
      end else begin
        send_item(FuncByte, 8'h41 + ByteW'($urandom_range(0, 25)));
      end
    end
    send_item(FuncEnd, 8'h00);
    steady = 1'b0;

    // Random settings, each with a handful of prompts and some noise
    base_items = items_sent;
    while (items_sent - base_items < RandomItems) begin
      case ($urandom_range(0, 3))
        0:       lim = CfgDW'($urandom_range(0, 12));
        1:       lim = CfgDW'($urandom_range(13, 8191));
        2:       lim = 13'd4096;
        default: lim = CfgDW'($urandom_range(20, 60));
      endcase
      apply_setting(CfgDW'($urandom_range(0, 8191)), CfgDW'($urandom_range(0, 8191)), lim);
      repeat ($urandom_range(3, 6)) begin
        r = $urandom_range(0, 99);
        if (r < 12) begin
          send_item(FuncW'($urandom_range(0, 3)), ByteW'($urandom_range(0, 255)));
        end else if (r < 17) begin
          send_prompt($urandom_range(20, 40), 1'b1, 1'b1);
        end else begin
          send_prompt($urandom_range(1, 14), $urandom_range(0, 9) != 0,
                      $urandom_range(0, 9) != 0);
        end
      end
    end

    drain();
    repeat (20) @(negedge clk_i);
    $display("Covered %0d input items in %0d prompts over %0d register settings;",
             items_sent, prompts_sent, settings_used);
    $display("%0d tokens checked, including token limit cuts and image count saturation.",
             checked_cnt);
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== hashed_word_tokenizer.f =====
+incdir+sv
sv/hwt_pkg.sv
sv/hwt_cfg_regs.sv
sv/hwt_word_hash.sv
sv/hwt_planner.sv
sv/hwt_emitter.sv
sv/hashed_word_tokenizer.sv
tb/sv/hashed_word_tokenizer_checker.sv
tb/sv/hashed_word_tokenizer_tb.sv
